/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define SIT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sit assertion failed");

// next-cycle implication
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sit assertion failed");

`endif

/* rtl/sit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// shared constants and types of the segment intersection test
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int COORD_BITS_DEF = 16;

   typedef logic [1:0] reject_type;

   localparam reject_type REJ_NONE     = 2'd0;
   localparam reject_type REJ_SHARED   = 2'd1;
   localparam reject_type REJ_PARALLEL = 2'd2;

   // quotient magnitude above 2^QSAT_BIT saturates outright
   localparam int QSAT_BIT = 40;

   localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic shared;
      logic parallel;
      logic hit;
      logic qneg_x;
      logic qneg_y;
   } flags_type;

endpackage

/* rtl/sit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_req_if / sit_rsp_if
// valid/ready channels of the segment intersection test
// ----------------------------------------------------------------------------
interface sit_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] seg_a_start_x;
   logic signed [COORD_BITS-1:0] seg_a_start_y;
   logic signed [COORD_BITS-1:0] seg_a_end_x;
   logic signed [COORD_BITS-1:0] seg_a_end_y;
   logic signed [COORD_BITS-1:0] seg_b_start_x;
   logic signed [COORD_BITS-1:0] seg_b_start_y;
   logic signed [COORD_BITS-1:0] seg_b_end_x;
   logic signed [COORD_BITS-1:0] seg_b_end_y;
   logic                         include_endpoints;

   modport source (output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                   seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
                   include_endpoints, input ready);
   modport sink (input valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                 seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
                 include_endpoints, output ready);
endinterface

interface sit_rsp_if ();
   logic               valid;
   logic               ready;
   logic               crosses;
   logic [1:0]         reject_reason;
   logic signed [31:0] cross_x;
   logic signed [31:0] cross_y;
   logic               point_saturated;

   modport source (output valid, crosses, reject_reason, cross_x, cross_y,
                   point_saturated, input ready);
   modport sink (input valid, crosses, reject_reason, cross_x, cross_y,
                 point_saturated, output ready);
endinterface

/* rtl/sit_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_front
// five-stage setup: differences, cross products, sign fix, range test and
// the dividend products for both axes
// ----------------------------------------------------------------------------
module sit_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sit_req_if.sink                              req,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [2*COORD_BITS+1:0]              out_d,
   output logic [3*COORD_BITS+1:0]              out_num_x,
   output logic [3*COORD_BITS+1:0]              out_num_y,
   output sit_pkg::flags_type                   out_flags,
   output logic signed [COORD_BITS-1:0]         out_ax0,
   output logic signed [COORD_BITS-1:0]         out_ay0
);
   import sit_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int NW = PW + CB;
   localparam int NS = 5;

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   rdy;
   logic [NS-1:0] vup;

   // stage 0: differences and shared endpoint check
   logic signed [DW-1:0] nax_ff, nay_ff, nbx_ff, nby_ff, wx_ff, wy_ff;
   logic signed [DW-1:0] nax_in, nay_in, nbx_in, nby_in, wx_in, wy_in;
   logic signed [CB-1:0] ax0_ff, ay0_ff;
   logic                 shared_ff, shared_in;
   // stage 1: products
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DW-1:0] nax1_ff, nay1_ff;
   logic signed [CB-1:0] ax01_ff, ay01_ff;
   logic                 shared1_ff;
   // stage 2: d, tnum, snum
   logic signed [SW-1:0] d_ff, tn_ff, sn_ff;
   logic signed [DW-1:0] nax2_ff, nay2_ff;
   logic signed [CB-1:0] ax02_ff, ay02_ff;
   logic                 shared2_ff;
   // stage 3: normalized
   logic signed [SW-1:0] dn, tnn, snn;
   logic                 dneg, tneg;
   logic [PW-1:0]        dm_ff, tm_ff, dm_in, tm_in;
   logic [CB-1:0]        mx_ff, my_ff, mx_in, my_in;
   flags_type            fl_ff, fl_in;
   logic signed [CB-1:0] ax03_ff, ay03_ff;
   // stage 4: dividends
   logic [PW-1:0]        dm4_ff;
   logic [NW-1:0]        nx_ff, ny_ff;
   flags_type            fl4_ff;
   logic signed [CB-1:0] ax04_ff, ay04_ff;

   assign req.ready = rdy[0];

   always_comb begin
      // ready runs from the output back toward the input
      rdy[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      vup[0] = req.valid;
      for (int i = 1; i < NS; i++) begin
         vup[i] = v_ff[i-1];
      end
      for (int i = 0; i < NS; i++) begin
         v_in[i] = rdy[i] ? vup[i] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign nax_in = DW'(req.seg_a_end_x) - DW'(req.seg_a_start_x);
   assign nay_in = DW'(req.seg_a_end_y) - DW'(req.seg_a_start_y);
   assign nbx_in = DW'(req.seg_b_end_x) - DW'(req.seg_b_start_x);
   assign nby_in = DW'(req.seg_b_end_y) - DW'(req.seg_b_start_y);
   assign wx_in  = DW'(req.seg_a_start_x) - DW'(req.seg_b_start_x);
   assign wy_in  = DW'(req.seg_a_start_y) - DW'(req.seg_b_start_y);
   assign shared_in = !req.include_endpoints &&
      ((req.seg_a_start_x == req.seg_b_start_x && req.seg_a_start_y == req.seg_b_start_y) ||
       (req.seg_a_end_x == req.seg_b_start_x && req.seg_a_end_y == req.seg_b_start_y) ||
       (req.seg_a_start_x == req.seg_b_end_x && req.seg_a_start_y == req.seg_b_end_y) ||
       (req.seg_a_end_x == req.seg_b_end_x && req.seg_a_end_y == req.seg_b_end_y));

   always_comb begin
      dneg = d_ff[SW-1];
      dn   = dneg ? -d_ff  : d_ff;
      tnn  = dneg ? -tn_ff : tn_ff;
      snn  = dneg ? -sn_ff : sn_ff;
      tneg = tnn[SW-1];
      dm_in = PW'(dn);
      tm_in = tneg ? PW'(-tnn) : PW'(tnn);
      mx_in = nax2_ff[DW-1] ? CB'(-nax2_ff) : CB'(nax2_ff);
      my_in = nay2_ff[DW-1] ? CB'(-nay2_ff) : CB'(nay2_ff);
      fl_in.shared   = shared2_ff;
      fl_in.parallel = (d_ff == '0);
      fl_in.hit      = !tnn[SW-1] && (tnn <= dn) && !snn[SW-1] && (snn <= dn);
      fl_in.qneg_x   = tneg != nax2_ff[DW-1];
      fl_in.qneg_y   = tneg != nay2_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         nax_ff <= nax_in; nay_ff <= nay_in; nbx_ff <= nbx_in; nby_ff <= nby_in;
         wx_ff <= wx_in; wy_ff <= wy_in;
         ax0_ff <= req.seg_a_start_x; ay0_ff <= req.seg_a_start_y;
         shared_ff <= shared_in;
      end
      if (rdy[1]) begin
         p0_ff <= PW'(nbx_ff) * PW'(nay_ff);
         p1_ff <= PW'(nby_ff) * PW'(nax_ff);
         p2_ff <= PW'(nby_ff) * PW'(wx_ff);
         p3_ff <= PW'(nbx_ff) * PW'(wy_ff);
         p4_ff <= PW'(nay_ff) * PW'(wx_ff);
         p5_ff <= PW'(nax_ff) * PW'(wy_ff);
         nax1_ff <= nax_ff; nay1_ff <= nay_ff;
         ax01_ff <= ax0_ff; ay01_ff <= ay0_ff; shared1_ff <= shared_ff;
      end
      if (rdy[2]) begin
         d_ff  <= SW'(p0_ff) - SW'(p1_ff);
         tn_ff <= SW'(p2_ff) - SW'(p3_ff);
         sn_ff <= SW'(p4_ff) - SW'(p5_ff);
         nax2_ff <= nax1_ff; nay2_ff <= nay1_ff;
         ax02_ff <= ax01_ff; ay02_ff <= ay01_ff; shared2_ff <= shared1_ff;
      end
      if (rdy[3]) begin
         dm_ff <= dm_in; tm_ff <= tm_in; mx_ff <= mx_in; my_ff <= my_in;
         fl_ff <= fl_in; ax03_ff <= ax02_ff; ay03_ff <= ay02_ff;
      end
      if (rdy[4]) begin
         nx_ff <= NW'(tm_ff) * NW'(mx_ff);
         ny_ff <= NW'(tm_ff) * NW'(my_ff);
         dm4_ff <= dm_ff; fl4_ff <= fl_ff; ax04_ff <= ax03_ff; ay04_ff <= ay03_ff;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_d     = dm4_ff;
   assign out_num_x = nx_ff;
   assign out_num_y = ny_ff;
   assign out_flags = fl4_ff;
   assign out_ax0   = ax04_ff;
   assign out_ay0   = ay04_ff;

endmodule

/* rtl/sit_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_div_cell
// one restoring division step for the x and y lanes, one quotient bit each
// ----------------------------------------------------------------------------
module sit_div_cell #(
   parameter int RW     = 35,
   parameter int NW     = 50,
   parameter int PW     = 34,
   parameter int SIDE_W = 37
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [PW-1:0]     in_d,
   input  logic [RW-1:0]     in_rem_x,
   input  logic [NW-1:0]     in_nq_x,
   input  logic [RW-1:0]     in_rem_y,
   input  logic [NW-1:0]     in_nq_y,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [PW-1:0]     out_d,
   output logic [RW-1:0]     out_rem_x,
   output logic [NW-1:0]     out_nq_x,
   output logic [RW-1:0]     out_rem_y,
   output logic [NW-1:0]     out_nq_y,
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_ff;
   logic [PW-1:0]     d_ff;
   logic [RW-1:0]     rem_x_ff, rem_y_ff, rem_x_in, rem_y_in, shx, shy;
   logic [NW-1:0]     nq_x_ff, nq_y_ff, nq_x_in, nq_y_in;
   logic [SIDE_W-1:0] side_ff;
   logic              gex, gey;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shx = {in_rem_x[RW-2:0], in_nq_x[NW-1]};
      shy = {in_rem_y[RW-2:0], in_nq_y[NW-1]};
      gex = shx >= RW'(in_d);
      gey = shy >= RW'(in_d);
      rem_x_in = gex ? shx - RW'(in_d) : shx;
      rem_y_in = gey ? shy - RW'(in_d) : shy;
      // dividend bits leave at the top, quotient bits enter at the bottom
      nq_x_in = {in_nq_x[NW-2:0], gex};
      nq_y_in = {in_nq_y[NW-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         d_ff <= in_d;
         rem_x_ff <= rem_x_in; rem_y_ff <= rem_y_in;
         nq_x_ff <= nq_x_in; nq_y_ff <= nq_y_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_d     = d_ff;
   assign out_rem_x = rem_x_ff;
   assign out_nq_x  = nq_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_nq_y  = nq_y_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/segment_intersection_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// exact integer test of two 2d segments with their line crossing point
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  req      in         valid & ready    two segments, include_endpoints
//  rsp      out        valid & ready    crosses, reject_reason, point, saturated
//
//  one transaction per cycle sustained, in and out, while rsp is ready
//  pipeline of five setup stages, one divider cell per quotient bit and one
//  output register
//  every stage stalls only when the stage after it is full and held
//  synchronous active-high reset clears the valid bits, not the payload
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test_top #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sit_req_if.sink   req,
   sit_rsp_if.source rsp
);
   import sit_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int PW     = 2 * (CB + 1);     // magnitude of d and tnum
   localparam int RW     = PW + 1;           // divider remainder
   localparam int NW     = PW + CB;          // dividend and quotient
   localparam int FW     = $bits(flags_type);
   localparam int SIDE_W = FW + 2 * CB;
   localparam int QX     = (NW > QSAT_BIT + 2) ? NW : QSAT_BIT + 2;
   localparam int VW     = QSAT_BIT + 3;     // start plus signed quotient

   // divider chain, index k feeds cell k
   logic              c_valid [NW+1];
   logic              c_ready [NW+1];
   logic [PW-1:0]     c_d     [NW+1];
   logic [RW-1:0]     c_rem_x [NW+1];
   logic [NW-1:0]     c_nq_x  [NW+1];
   logic [RW-1:0]     c_rem_y [NW+1];
   logic [NW-1:0]     c_nq_y  [NW+1];
   logic [SIDE_W-1:0] c_side  [NW+1];

   flags_type            f_flags, fl;
   logic signed [CB-1:0] f_ax0, f_ay0, ax0, ay0;

   sit_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .out_d     (c_d[0]),
      .out_num_x (c_nq_x[0]),
      .out_num_y (c_nq_y[0]),
      .out_flags (f_flags),
      .out_ax0   (f_ax0),
      .out_ay0   (f_ay0)
   );

   // remainders start empty, the side band carries flags and start point
   assign c_rem_x[0] = '0;
   assign c_rem_y[0] = '0;
   assign c_side[0]  = {f_flags, f_ax0, f_ay0};

   for (genvar k = 0; k < NW; k++) begin : g_cell
      sit_div_cell #(.RW(RW), .NW(NW), .PW(PW), .SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[k]),
         .in_ready  (c_ready[k]),
         .in_d      (c_d[k]),
         .in_rem_x  (c_rem_x[k]),
         .in_nq_x   (c_nq_x[k]),
         .in_rem_y  (c_rem_y[k]),
         .in_nq_y   (c_nq_y[k]),
         .in_side   (c_side[k]),
         .out_valid (c_valid[k+1]),
         .out_ready (c_ready[k+1]),
         .out_d     (c_d[k+1]),
         .out_rem_x (c_rem_x[k+1]),
         .out_nq_x  (c_nq_x[k+1]),
         .out_rem_y (c_rem_y[k+1]),
         .out_nq_y  (c_nq_y[k+1]),
         .out_side  (c_side[k+1])
      );
   end

   // output register
   logic               rsp_valid_ff;
   logic               crosses_ff, crosses_in;
   reject_type         reason_ff, reason_in;
   logic signed [31:0] cx_ff, cy_ff, cx_in, cy_in;
   logic               sat_ff, sat_in;
   logic               out_load;

   logic [QX-1:0]        qx, qy;
   logic                 ovx, ovy, satx, saty;
   logic signed [VW-1:0] vx, vy;

   assign out_load = !rsp_valid_ff || rsp.ready;
   assign c_ready[NW] = out_load;
   assign {fl, ax0, ay0} = c_side[NW];

   always_comb begin
      qx = QX'(c_nq_x[NW]);
      qy = QX'(c_nq_y[NW]);
      // quotient beyond 2^40 clamps without the add
      ovx = (qx[QX-1:QSAT_BIT+1] != '0) || (qx[QSAT_BIT] && (qx[QSAT_BIT-1:0] != '0));
      ovy = (qy[QX-1:QSAT_BIT+1] != '0) || (qy[QSAT_BIT] && (qy[QSAT_BIT-1:0] != '0));
      vx = VW'(ax0) + (fl.qneg_x ? -VW'(qx[QSAT_BIT:0]) : VW'(qx[QSAT_BIT:0]));
      vy = VW'(ay0) + (fl.qneg_y ? -VW'(qy[QSAT_BIT:0]) : VW'(qy[QSAT_BIT:0]));
      satx = 1'b1;
      saty = 1'b1;
      if (ovx) begin
         cx_in = fl.qneg_x ? INT32_MIN : INT32_MAX;
      end else if (vx > VW'(INT32_MAX)) begin
         cx_in = INT32_MAX;
      end else if (vx < VW'(INT32_MIN)) begin
         cx_in = INT32_MIN;
      end else begin
         cx_in = vx[31:0];
         satx  = 1'b0;
      end
      if (ovy) begin
         cy_in = fl.qneg_y ? INT32_MIN : INT32_MAX;
      end else if (vy > VW'(INT32_MAX)) begin
         cy_in = INT32_MAX;
      end else if (vy < VW'(INT32_MIN)) begin
         cy_in = INT32_MIN;
      end else begin
         cy_in = vy[31:0];
         saty  = 1'b0;
      end
      crosses_in = fl.hit;
      sat_in     = satx || saty;
      reason_in  = REJ_NONE;
      // shared endpoint wins over parallel; both give a zero point
      if (fl.shared || fl.parallel) begin
         reason_in  = fl.shared ? REJ_SHARED : REJ_PARALLEL;
         crosses_in = 1'b0;
         cx_in      = '0;
         cy_in      = '0;
         sat_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= c_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         crosses_ff <= crosses_in;
         reason_ff  <= reason_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         sat_ff     <= sat_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.crosses         = crosses_ff;
   assign rsp.reject_reason   = reason_ff;
   assign rsp.cross_x         = cx_ff;
   assign rsp.cross_y         = cy_ff;
   assign rsp.point_saturated = sat_ff;

   // a rejected pair carries an all-zero point
   `SIT_ASSERT_NOW(a_reject_zero, rsp.valid && (rsp.reject_reason != REJ_NONE),
      !rsp.crosses && (rsp.cross_x == 0) && (rsp.cross_y == 0) && !rsp.point_saturated)
   // a crossing is only reported for a computed point
   `SIT_ASSERT_NOW(a_cross_computed, rsp.valid && rsp.crosses,
      rsp.reject_reason == REJ_NONE)
   // a point on segment a never needs clamping
   `SIT_ASSERT_NOW(a_cross_unclamped, rsp.valid && rsp.crosses, !rsp.point_saturated)
   // a clamped point sits on a 32-bit bound
   `SIT_ASSERT_NOW(a_sat_bound, rsp.valid && rsp.point_saturated,
      (rsp.cross_x == INT32_MAX) || (rsp.cross_x == INT32_MIN) ||
      (rsp.cross_y == INT32_MAX) || (rsp.cross_y == INT32_MIN))
   // a finished divider output lands in an empty or draining output register
   `SIT_ASSERT_NEXT(a_out_capture, c_valid[NW] && out_load, rsp.valid)

endmodule
